@@ rtl/paa_pkg.sv @@
// ----------------------------------------------------------------------------
// paa_pkg
// Shared types and codes for the pointer acceleration accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package paa_pkg;

  localparam int unsigned CntW = 5;

  // register indexes
  localparam logic [1:0] REG_PROFILE   = 2'd0;
  localparam logic [1:0] REG_GAIN      = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  // profiles
  localparam logic [1:0] PROF_NONE   = 2'd0;
  localparam logic [1:0] PROF_LINEAR = 2'd1;
  localparam logic [1:0] PROF_EASED  = 2'd2;
  localparam logic [1:0] PROF_FIXED  = 2'd3;

  // datapath operations
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_SQRT_STEP = 4'd2;
  localparam logic [3:0] OP_F_LIN     = 4'd3;
  localparam logic [3:0] OP_DIV_STEP  = 4'd4;
  localparam logic [3:0] OP_G_DONE    = 4'd5;
  localparam logic [3:0] OP_TERM_MUL  = 4'd6;
  localparam logic [3:0] OP_TERM_ACC  = 4'd7;
  localparam logic [3:0] OP_CAP       = 4'd8;
  localparam logic [3:0] OP_SQUARE    = 4'd9;
  localparam logic [3:0] OP_F_EXP     = 4'd10;
  localparam logic [3:0] OP_SCALE_X   = 4'd11;
  localparam logic [3:0] OP_SCALE_Y   = 4'd12;
  localparam logic [3:0] OP_COMMIT    = 4'd13;
  localparam logic [3:0] OP_TERM_DIV  = 4'd14;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] profile;
    logic       m_zero;
    logic       exp_zero;
    logic       k_end;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/paa_ctrl.sv @@
// ----------------------------------------------------------------------------
// paa_ctrl
// Sequencer: steps the datapath through one request and runs the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module paa_ctrl
  import paa_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SQRT   = 4'd2;
  localparam logic [3:0] S_FLIN   = 4'd3;
  localparam logic [3:0] S_GDIV   = 4'd4;
  localparam logic [3:0] S_GDONE  = 4'd5;
  localparam logic [3:0] S_TMUL   = 4'd6;
  localparam logic [3:0] S_TDIV   = 4'd7;
  localparam logic [3:0] S_TACC   = 4'd8;
  localparam logic [3:0] S_CAP    = 4'd9;
  localparam logic [3:0] S_SQ     = 4'd10;
  localparam logic [3:0] S_FEXP   = 4'd11;
  localparam logic [3:0] S_SCX    = 4'd12;
  localparam logic [3:0] S_SCY    = 4'd13;
  localparam logic [3:0] S_COMMIT = 4'd14;

  localparam logic [CntW-1:0] LastStep   = CntW'(23);
  localparam logic [CntW-1:0] LastSquare = CntW'(3);

  logic [3:0]      state, state_next;
  logic [CntW-1:0] cnt, cnt_next;
  logic            out_valid_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = OP_NONE;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        cnt_next = '0;
        if (status.profile == PROF_LINEAR) begin
          state_next = S_SQRT;
        end else if (status.profile == PROF_EASED) begin
          state_next = (status.exp_zero || status.m_zero) ? S_FEXP : S_GDIV;
        end else begin
          state_next = S_SCX;
        end
      end
      S_SQRT: begin
        cmd.op   = OP_SQRT_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == LastStep) state_next = S_FLIN;
      end
      S_FLIN: begin
        cmd.op     = OP_F_LIN;
        state_next = S_SCX;
      end
      S_GDIV: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == LastStep) state_next = S_GDONE;
      end
      S_GDONE: begin
        cmd.op     = OP_G_DONE;
        state_next = S_TMUL;
      end
      S_TMUL: begin
        cmd.op     = OP_TERM_MUL;
        state_next = S_TDIV;
      end
      S_TDIV: begin
        cmd.op     = OP_TERM_DIV;
        state_next = S_TACC;
      end
      S_TACC: begin
        cmd.op     = OP_TERM_ACC;
        state_next = status.k_end ? S_CAP : S_TMUL;
      end
      S_CAP: begin
        cmd.op     = OP_CAP;
        cnt_next   = '0;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op   = OP_SQUARE;
        cnt_next = cnt + 1'b1;
        if (cnt == LastSquare) state_next = S_FEXP;
      end
      S_FEXP: begin
        cmd.op     = OP_F_EXP;
        state_next = S_SCX;
      end
      S_SCX: begin
        cmd.op     = OP_SCALE_X;
        state_next = S_SCY;
      end
      S_SCY: begin
        cmd.op     = OP_SCALE_Y;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (!(out_valid && out_stall)) begin
          cmd.op     = OP_COMMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.op == OP_COMMIT) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/paa_datapath.sv @@
// ----------------------------------------------------------------------------
// paa_datapath
// Config registers, square root and divider units, shared multiplier, totals.
// ----------------------------------------------------------------------------
`default_nettype none

module paa_datapath
  import paa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        write_enable,
  input  wire logic [1:0]  reg_index,
  input  wire logic [15:0] write_data,
  input  wire logic [15:0] delta_x,
  input  wire logic [15:0] delta_y,
  input  wire logic [7:0]  button_mask,
  input  wire logic [7:0]  wheel_step,
  input  wire logic [7:0]  hwheel_step,
  input  wire cmd_t        cmd,
  output status_t          status,
  output logic [31:0]      acc_x,
  output logic [31:0]      acc_y,
  output logic [7:0]       held_buttons,
  output logic [31:0]      acc_wheel,
  output logic [31:0]      acc_hwheel
);

  logic [1:0]  profile;
  logic [11:0] gain;
  logic [15:0] threshold;
  logic [15:0] t_eff;

  logic [16:0] ax, ay, sx_in, sy_in;
  logic [16:0] ax_in, ay_in, m_in;
  logic        neg_x, neg_y;
  logic [16:0] m;
  logic [7:0]  wheel_in, hwheel_in, buttons_in;

  logic [47:0] rem_x, rem_y, root_x, root_y, sq_bit;
  logic [48:0] trial_x, trial_y;

  logic [16:0] divisor, drem;
  logic [23:0] dshift, quot;
  logic [17:0] dtrial;

  logic [23:0] g, term, tq;
  logic [32:0] x;
  logic [3:0]  k;
  logic [28:0] f;
  logic [31:0] sc_x, sc_y;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [16:0] e_val, one_minus_e;
  logic [24:0] s_sum;
  logic [31:0] add_x, add_y;

  // ceil(2^28 / k): exact quotient of a 24-bit value by k as (v * r) >> 28
  function automatic logic [27:0] recip_k(input logic [3:0] kk);
    logic [27:0] r;
    case (kk)
      4'd2:    r = 28'd134217728;
      4'd3:    r = 28'd89478486;
      4'd4:    r = 28'd67108864;
      4'd5:    r = 28'd53687092;
      4'd6:    r = 28'd44739243;
      4'd7:    r = 28'd38347923;
      4'd8:    r = 28'd33554432;
      4'd9:    r = 28'd29826162;
      4'd10:   r = 28'd26843546;
      4'd11:   r = 28'd24403224;
      default: r = 28'd22369622;
    endcase
    return r;
  endfunction

  assign t_eff = (threshold == '0) ? 16'd1 : threshold;

  assign sx_in = {delta_x[15], delta_x};
  assign sy_in = {delta_y[15], delta_y};
  assign ax_in = delta_x[15] ? (17'd0 - sx_in) : sx_in;
  assign ay_in = delta_y[15] ? (17'd0 - sy_in) : sy_in;
  assign m_in  = ax_in + ay_in;

  assign status.profile  = profile;
  assign status.m_zero   = (m == '0);
  assign status.exp_zero = ({m, 8'd0} >= ({5'd0, t_eff, 4'd0} - {7'd0, t_eff, 2'd0}));
  assign status.k_end    = (k == 4'd12);

  assign trial_x = {1'b0, root_x} + {1'b0, sq_bit};
  assign trial_y = {1'b0, root_y} + {1'b0, sq_bit};
  assign dtrial  = {drem, dshift[23]};
  assign s_sum   = {1'b0, root_x[23:0]} + {1'b0, root_y[23:0]};

  always_comb begin
    if (status.exp_zero) begin
      e_val = '0;
    end else if (status.m_zero) begin
      e_val = 17'h10000;
    end else begin
      e_val = {1'b0, x[31:16]};
    end
  end
  assign one_minus_e = 17'h10000 - e_val;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_F_LIN:    begin mul_a = {20'd0, gain}; mul_b = {7'd0, s_sum}; end
      OP_F_EXP:    begin mul_a = {20'd0, gain}; mul_b = {15'd0, one_minus_e}; end
      OP_TERM_MUL: begin mul_a = {8'd0, term}; mul_b = {8'd0, g}; end
      OP_TERM_DIV: begin mul_a = {8'd0, tq}; mul_b = {4'd0, recip_k(k)}; end
      OP_SQUARE:   begin mul_a = x[31:0]; mul_b = x[31:0]; end
      OP_SCALE_X:  begin mul_a = {15'd0, ax}; mul_b = {3'd0, f}; end
      OP_SCALE_Y:  begin mul_a = {15'd0, ay}; mul_b = {3'd0, f}; end
      default:     begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  assign add_x = neg_x ? (32'd0 - sc_x) : sc_x;
  assign add_y = neg_y ? (32'd0 - sc_y) : sc_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      profile   <= PROF_NONE;
      gain      <= '0;
      threshold <= 16'd256;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_PROFILE:   profile   <= write_data[1:0];
        REG_GAIN:      gain      <= write_data[11:0];
        REG_THRESHOLD: threshold <= write_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x        <= '0;
      acc_y        <= '0;
      held_buttons <= '0;
      acc_wheel    <= '0;
      acc_hwheel   <= '0;
    end else if (cmd.op == OP_COMMIT) begin
      acc_x        <= acc_x + add_x;
      acc_y        <= acc_y + add_y;
      held_buttons <= buttons_in;
      acc_wheel    <= acc_wheel + {{24{wheel_in[7]}}, wheel_in};
      acc_hwheel   <= acc_hwheel + {{24{hwheel_in[7]}}, hwheel_in};
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        ax         <= ax_in;
        ay         <= ay_in;
        m          <= m_in;
        neg_x      <= delta_x[15];
        neg_y      <= delta_y[15];
        buttons_in <= button_mask;
        wheel_in   <= wheel_step;
        hwheel_in  <= hwheel_step;
        rem_x      <= {ax_in[15:0], 32'd0};
        rem_y      <= {ay_in[15:0], 32'd0};
        root_x     <= '0;
        root_y     <= '0;
        sq_bit     <= 48'd1 << 46;
        divisor    <= {1'b0, t_eff};
        drem       <= {m_in[12:0], 4'd0};
        dshift     <= '0;
        quot       <= '0;
        f          <= (profile == PROF_FIXED) ? (29'h10000 + {9'd0, gain, 8'd0})
                                              : 29'h10000;
      end
      OP_SQRT_STEP: begin
        if ({1'b0, rem_x} >= trial_x) begin
          rem_x  <= rem_x - trial_x[47:0];
          root_x <= (root_x >> 1) + sq_bit;
        end else begin
          root_x <= root_x >> 1;
        end
        if ({1'b0, rem_y} >= trial_y) begin
          rem_y  <= rem_y - trial_y[47:0];
          root_y <= (root_y >> 1) + sq_bit;
        end else begin
          root_y <= root_y >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      OP_F_LIN: f <= 29'h10000 + {1'b0, prod[36:9]};
      OP_DIV_STEP: begin
        dshift <= {dshift[22:0], 1'b0};
        if (dtrial >= {1'b0, divisor}) begin
          drem <= 17'(dtrial - {1'b0, divisor});
          quot <= {quot[22:0], 1'b1};
        end else begin
          drem <= dtrial[16:0];
          quot <= {quot[22:0], 1'b0};
        end
      end
      OP_G_DONE: begin
        g    <= quot;
        term <= quot;
        x    <= 33'h1_0000_0000 - {9'd0, quot};
        k    <= 4'd2;
      end
      OP_TERM_MUL: tq   <= prod[55:32];
      OP_TERM_DIV: quot <= prod[51:28];
      OP_TERM_ACC: begin
        term <= quot;
        x    <= k[0] ? (x - {9'd0, quot}) : (x + {9'd0, quot});
        k    <= k + 4'd1;
      end
      OP_CAP:     if (x[32]) x <= 33'h0_FFFF_FFFF;
      OP_SQUARE:  x <= {1'b0, prod[63:32]};
      OP_F_EXP:   f <= 29'h10000 + {8'd0, prod[28:8]};
      OP_SCALE_X: sc_x <= prod[47:16];
      OP_SCALE_Y: sc_y <= prod[47:16];
      default:    ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/pointer_accel_accumulator.sv @@
// From acceptance to the result being offered: none and fixed go straight to scaling;
// linear first runs 24-step square roots; eased runs a 24-step divider, eleven series
// terms and four squarings, or none of these when exp is 0 or 1.
// Throughput: one request at a time, the next taken in the cycle after the commit;
// the commit waits while an earlier result is still stalled.
// Reset: synchronous; totals and buttons cleared, profile none, gain 0, threshold 1.0.
// ----------------------------------------------------------------------------
// pointer_accel_accumulator
// Pointer event acceleration and position/wheel accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module pointer_accel_accumulator
  import paa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               write_enable,
  input  wire logic [1:0]         reg_index,
  input  wire logic [15:0]        write_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] delta_x,
  input  wire logic signed [15:0] delta_y,
  input  wire logic [7:0]         button_mask,
  input  wire logic signed [7:0]  wheel_step,
  input  wire logic signed [7:0]  hwheel_step,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic [7:0]              buttons_now,
  output logic signed [31:0]      wheel_total,
  output logic signed [31:0]      hwheel_total
);

  cmd_t        cmd;
  status_t     status;
  logic [31:0] acc_x, acc_y, acc_wheel, acc_hwheel;
  logic [7:0]  held_buttons;

  paa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  paa_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .delta_x      (delta_x),
    .delta_y      (delta_y),
    .button_mask  (button_mask),
    .wheel_step   (wheel_step),
    .hwheel_step  (hwheel_step),
    .cmd          (cmd),
    .status       (status),
    .acc_x        (acc_x),
    .acc_y        (acc_y),
    .held_buttons (held_buttons),
    .acc_wheel    (acc_wheel),
    .acc_hwheel   (acc_hwheel)
  );

  assign pos_x        = acc_x;
  assign pos_y        = acc_y;
  assign buttons_now  = held_buttons;
  assign wheel_total  = acc_wheel;
  assign hwheel_total = acc_hwheel;

endmodule

`default_nettype wire

@@ bench/pointer_accel_accumulator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_accel_accumulator_test
// Drives pointer events through the accelerator under every acceleration
// profile. A directed table comes first, then randomised phases with new
// register settings. Each returned total set is checked against the table or
// an in-bench model of acceleration and accumulation. Both handshakes idle
// and stall at random, and the output is held off once for a long stretch.
// ----------------------------------------------------------------------------

module pointer_accel_accumulator_test;
  import paa_pkg::*;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [7:0]         buttons;
    logic signed [31:0] wheel;
    logic signed [31:0] hwheel;
  } totals_t;

  typedef struct {
    bit                 is_cfg;
    logic [1:0]         idx;
    logic [15:0]        data;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [7:0]         btn;
    logic signed [7:0]  wh;
    logic signed [7:0]  hwh;
    bit                 has_exp;
    totals_t            exp_tot;
  } step_t;

  localparam int NumRows = 23;
  localparam totals_t NoTot = '{0, 0, 0, 0, 0};
  // index with no register behind it
  localparam logic [1:0] RegUnused = 2'd3;

  logic clk = 0;
  logic rst = 1;
  logic write_enable = 0;
  logic [1:0] reg_index = '0;
  logic [15:0] write_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] delta_x = '0;
  logic signed [15:0] delta_y = '0;
  logic [7:0] button_mask = '0;
  logic signed [7:0] wheel_step = '0;
  logic signed [7:0] hwheel_step = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] pos_x, pos_y, wheel_total, hwheel_total;
  logic [7:0] buttons_now;

  logic [1:0]  cur_profile = PROF_NONE;
  logic [11:0] cur_gain = '0;
  logic [15:0] cur_threshold = 16'd256;
  totals_t     model_tot = NoTot;
  totals_t     pending_totals[$];
  int          err_cnt = 0;
  int          accepted_cnt = 0;

  step_t dir_tab [NumRows] = '{
    '{0, 0, 0, 16'sh7FFF, 16'sh8000, 8'hFF, 8'sh7F, 8'sh80, 1,
      '{32767, -32768, 8'hFF, 127, -128}},
    '{0, 0, 0, 16'sh8000, 16'sh7FFF, 8'h00, 8'sh80, 8'sh7F, 1,
      '{-1, -1, 8'h00, -1, -1}},
    '{0, 0, 0, 16'sh0000, 16'sh0000, 8'h55, 8'sh00, 8'sh00, 1,
      '{-1, -1, 8'h55, -1, -1}},
    '{1, REG_GAIN, 16'hFFFF, 0, 0, 0, 0, 0, 0, NoTot},
    '{1, REG_PROFILE, 16'(PROF_LINEAR), 0, 0, 0, 0, 0, 0, NoTot},
    '{0, 0, 0, 16'sh7FFF, 16'sh8000, 8'hAA, 8'sh01, 8'shFF, 0, NoTot},
    '{0, 0, 0, 16'sh0001, 16'shFFFF, 8'h00, 8'sh00, 8'sh00, 0, NoTot},
    '{0, 0, 0, 16'sh0000, 16'sh0000, 8'h00, 8'sh00, 8'sh00, 0, NoTot},
    '{1, REG_THRESHOLD, 16'h0000, 0, 0, 0, 0, 0, 0, NoTot},
    '{1, REG_PROFILE, 16'(PROF_EASED), 0, 0, 0, 0, 0, 0, NoTot},
    '{0, 0, 0, 16'sh0001, 16'sh0000, 8'h01, 8'sh00, 8'sh00, 0, NoTot},
    '{0, 0, 0, 16'sh0000, 16'sh0000, 8'h02, 8'sh00, 8'sh00, 0, NoTot},
    '{0, 0, 0, 16'sh7FFF, 16'sh7FFF, 8'h04, 8'sh7F, 8'sh7F, 0, NoTot},
    '{1, REG_THRESHOLD, 16'hFFFF, 0, 0, 0, 0, 0, 0, NoTot},
    '{0, 0, 0, 16'sh0064, 16'sh0000, 8'h08, 8'sh00, 8'sh00, 0, NoTot},
    '{0, 0, 0, 16'sh0BB8, 16'shFF00, 8'h10, 8'sh80, 8'sh80, 0, NoTot},
    '{1, RegUnused, 16'hFFFF, 0, 0, 0, 0, 0, 0, NoTot},
    '{1, REG_PROFILE, 16'hFFFF, 0, 0, 0, 0, 0, 0, NoTot},
    '{0, 0, 0, 16'sh8000, 16'sh8000, 8'h20, 8'sh00, 8'sh00, 0, NoTot},
    '{0, 0, 0, 16'shFFFF, 16'sh0001, 8'h40, 8'sh00, 8'sh00, 0, NoTot},
    '{1, REG_GAIN, 16'h0000, 0, 0, 0, 0, 0, 0, NoTot},
    '{0, 0, 0, 16'sh7FFF, 16'sh8000, 8'h80, 8'sh00, 8'sh00, 0, NoTot},
    '{1, REG_THRESHOLD, 16'h0100, 0, 0, 0, 0, 0, 0, NoTot}
  };

  pointer_accel_accumulator i_dut (.*);

  always #4 clk = ~clk;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned rem, root, bt;
    rem = v;
    root = 0;
    bt = 64'd1 << 62;
    while (bt != 0) begin
      if (rem >= root + bt) begin
        rem -= root + bt;
        root = (root >> 1) + bt;
      end else begin
        root >>= 1;
      end
      bt >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned exp_q16(longint unsigned m, longint unsigned t);
    longint unsigned g, x, term;
    if (m * 256 >= t * 12) return 0;
    if (m == 0) return 65536;
    g = (m << 28) / t;
    x = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * g) >> 32) / k;
      if (k % 2) x -= term;
      else x += term;
    end
    if (x > 64'hFFFF_FFFF) x = 64'hFFFF_FFFF;
    for (int k = 0; k < 4; k++) x = (x * x) >> 32;
    return x >> 16;
  endfunction

  function automatic logic [31:0] scaled(logic signed [15:0] d, longint unsigned f);
    longint unsigned mag;
    logic [31:0] r;
    mag = (d < 0) ? longint'(-int'(d)) : longint'(d);
    r = 32'((mag * f) >> 16);
    return (d < 0) ? -r : r;
  endfunction

  // advance the running totals by one pointer event
  function automatic totals_t next_totals(totals_t cur, logic signed [15:0] dx,
                                          logic signed [15:0] dy, logic [7:0] btn,
                                          logic signed [7:0] wh, logic signed [7:0] hwh);
    longint unsigned ax, ay, f, thr;
    totals_t nt;
    ax = (dx < 0) ? longint'(-int'(dx)) : longint'(dx);
    ay = (dy < 0) ? longint'(-int'(dy)) : longint'(dy);
    thr = (cur_threshold == 0) ? 1 : cur_threshold;
    case (cur_profile)
      PROF_LINEAR: f = 65536 + ((cur_gain * (root64(ax << 32) + root64(ay << 32))) >> 9);
      PROF_EASED:  f = 65536 + ((cur_gain * (65536 - exp_q16(ax + ay, thr))) >> 8);
      PROF_FIXED:  f = 65536 + (longint'(cur_gain) << 8);
      default:     f = 65536;
    endcase
    nt.pos_x = cur.pos_x + scaled(dx, f);
    nt.pos_y = cur.pos_y + scaled(dy, f);
    nt.buttons = btn;
    nt.wheel = cur.wheel + 32'(wh);
    nt.hwheel = cur.hwheel + 32'(hwh);
    return nt;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_event(logic signed [15:0] dx, logic signed [15:0] dy,
                            logic [7:0] btn, logic signed [7:0] wh,
                            logic signed [7:0] hwh, bit has_exp, totals_t exp_tot);
    delta_x = dx;
    delta_y = dy;
    button_mask = btn;
    wheel_step = wh;
    hwheel_step = hwh;
    in_valid = 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_tot = next_totals(model_tot, dx, dy, btn, wh, hwh);
    pending_totals.push_back(has_exp ? exp_tot : model_tot);
    accepted_cnt++;
    @(negedge clk);
  endtask

  // called at a falling edge; writes once every result has come back
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    in_valid = 0;
    while (pending_totals.size() != 0) @(negedge clk);
    write_enable = 1;
    reg_index = idx;
    write_data = data;
    @(negedge clk);
    write_enable = 0;
    case (idx)
      REG_PROFILE:   cur_profile = data[1:0];
      REG_GAIN:      cur_gain = data[11:0];
      REG_THRESHOLD: cur_threshold = data;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    totals_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_totals.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = pending_totals.pop_front();
        if (pos_x !== e.pos_x || pos_y !== e.pos_y || buttons_now !== e.buttons ||
            wheel_total !== e.wheel || hwheel_total !== e.hwheel) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch at %0t: exp %0d %0d %h %0d %0d got %0d %0d %h %0d %0d",
                     $realtime, e.pos_x, e.pos_y, e.buttons, e.wheel, e.hwheel,
                     pos_x, pos_y, buttons_now, wheel_total, hwheel_total);
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    bit held_off;
    held_off = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!held_off && accepted_cnt >= 40) begin
        out_stall = 1;
        repeat (400) @(negedge clk);
        held_off = 1;
      end else if ($urandom_range(0, 9) == 0) begin
        out_stall = 0;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end else begin
        out_stall = ($urandom_range(0, 2) == 0);
      end
    end
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int burst_left;
    logic signed [15:0] rx, ry;
    totals_t none_tot;
    none_tot = NoTot;
    burst_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    for (int i = 0; i < NumRows; i++) begin
      if (dir_tab[i].is_cfg) begin
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_event(dir_tab[i].dx, dir_tab[i].dy, dir_tab[i].btn, dir_tab[i].wh,
                   dir_tab[i].hwh, dir_tab[i].has_exp, dir_tab[i].exp_tot);
      end
    end

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_PROFILE, 16'($urandom_range(0, 3)));
      case ($urandom_range(0, 2))
        0: write_reg(REG_GAIN, 16'h0FFF);
        1: write_reg(REG_GAIN, 16'h0000);
        default: write_reg(REG_GAIN, 16'($urandom));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(REG_THRESHOLD, 16'hFFFF);
        1: write_reg(REG_THRESHOLD, 16'h0001);
        default: write_reg(REG_THRESHOLD, 16'($urandom));
      endcase
      for (int n = 0; n < 150; n++) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) begin
            in_valid = 0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
          end
          burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        if ($urandom_range(0, 2) == 0) begin
          rx = 16'($urandom_range(0, 64)) - 16'sd32;
          ry = 16'($urandom_range(0, 64)) - 16'sd32;
        end else begin
          rx = 16'($urandom);
          ry = 16'($urandom);
        end
        send_event(rx, ry, 8'($urandom), 8'($urandom), 8'($urandom), 0, none_tot);
      end
    end

    in_valid = 0;
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/paa_pkg.sv
rtl/paa_ctrl.sv
rtl/paa_datapath.sv
rtl/pointer_accel_accumulator.sv
bench/pointer_accel_accumulator_test.sv
